// ===== hw/rtl/fragment_reassembly_engine_unit_defines.svh =====
// Assertion macros for the fragment reassembly engine checker.
// Depends on nothing; expects clk_i and rst_ni in the scope that uses it.
`ifndef FRAGMENT_REASSEMBLY_ENGINE_UNIT_DEFINES_SVH
`define FRAGMENT_REASSEMBLY_ENGINE_UNIT_DEFINES_SVH

// Checked at every rising edge while out of reset.
`define FRE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Checked at every rising edge, reset included.
`define FRE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hw/rtl/fre_pkg.sv =====
// Shared types and constants of the fragment reassembly engine.
// Used by the top level and the checker; depends on nothing.
package fre_pkg;

  localparam int unsigned DefChannels  = 8;
  localparam int unsigned DefMaxFrags  = 32;
  localparam int unsigned DefFragBytes = 64;

  // Misses reported when a channel holds more fragments than its total.
  localparam logic [5:0] MissesInconsistent = 6'd63;
  localparam logic [5:0] TotalMax           = 6'd63;

  typedef enum logic [1:0] {
    MODE_STORE = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_READ  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_BYTE   = 2'd0,
    ST_STATUS = 2'd1,
    ST_ABSENT = 2'd2,
    ST_ACK    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_e;

  typedef struct packed {
    status_e    status;
    logic [7:0] byte_out;
    logic       last;
    logic       seen;
    logic [5:0] misses;
    logic       complete;
  } result_t;

endpackage

// ===== hw/rtl/fre_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module fre_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/fragment_reassembly_engine_unit.sv =====
// Top level of the fragment reassembly engine.
// Depends on fre_pkg and fre_ram.

// Fragment reassembly engine: stores fragment bytes per channel, sequence
// and offset, and answers status queries, fragment reads and channel clears.
// Every word is taken into a register and the channel's state word and the
// fragment length are read from their memories; the word is worked the cycle
// after. Stores follow one another every cycle, since a channel state word
// written in one cycle is forwarded to the word accepted in that same cycle.
// A query, a clear or a read that finds the fragment absent completes once
// the result register is free, and waits for as long as it stays full. A
// read of a stored fragment moves to the read state and passes its bytes one
// by one from the read port of the payload memory to the result register;
// no word is accepted until its last byte has gone into the result register.
// A finished result may wait in the result register while the next word is
// accepted. Channel state resets through one valid flag per channel, so no
// clearing pass follows reset.
module fragment_reassembly_engine_unit #(
  parameter int unsigned CHANNELS   = fre_pkg::DefChannels,
  parameter int unsigned MAX_FRAGS  = fre_pkg::DefMaxFrags,
  parameter int unsigned FRAG_BYTES = fre_pkg::DefFragBytes
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] mode_i,
  input  logic [2:0] channel_i,
  input  logic [4:0] seq_i,
  input  logic [5:0] left_i,
  input  logic [5:0] offset_i,
  input  logic       frag_end_i,
  input  logic [7:0] data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic [7:0] byte_out_o,
  output logic       last_o,
  output logic       seen_o,
  output logic [5:0] misses_o,
  output logic       complete_o
);

  localparam int unsigned CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SW    = (MAX_FRAGS > 1) ? $clog2(MAX_FRAGS) : 1;
  localparam int unsigned CNW   = $clog2(MAX_FRAGS + 1);
  localparam int unsigned LNW   = $clog2(FRAG_BYTES + 1);
  localparam int unsigned SLOTS = CHANNELS * MAX_FRAGS;
  localparam int unsigned LAW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned BYTES = SLOTS * FRAG_BYTES;
  localparam int unsigned PAW   = (BYTES > 1) ? $clog2(BYTES) : 1;

  typedef struct packed {
    logic [MAX_FRAGS-1:0] rx_map;
    logic [CNW-1:0]       rx_count;
    logic [5:0]           total;
    logic [SW-1:0]        low_seq;
  } chan_t;

  localparam int unsigned EW = $bits(chan_t);
  localparam chan_t ChanReset = '{
    rx_map:   '0,
    rx_count: '0,
    total:    '0,
    low_seq:  SW'(MAX_FRAGS - 1)
  };

  // Control state.
  fre_pkg::state_e state_q, state_d;
  logic [CHANNELS-1:0] cvalid_q, cvalid_d;
  logic                out_valid_q, out_valid_d;
  logic                byp_q, byp_d;
  logic                lbyp_q, lbyp_d;
  logic                pend_q, pend_d;
  logic                pend_last_q, pend_last_d;
  logic [LNW-1:0]      rd_idx_q, rd_idx_d;

  // Payload registers.
  fre_pkg::mode_e   mode_q;
  logic [2:0]       ch_q;
  logic [4:0]       seq_q;
  logic [5:0]       left_q;
  logic [5:0]       off_q;
  logic             fe_q;
  logic [7:0]       data_q;
  logic [LAW-1:0]   slot_q;
  chan_t            byp_ent_q;
  logic [LNW-1:0]   lbyp_len_q;
  logic [LNW-1:0]   len_q, len_d;
  fre_pkg::result_t out_q, out_d;

  logic             in_acc;
  logic [LAW-1:0]   slot_in;
  logic [CW-1:0]    cidx;
  logic [SW-1:0]    sidx;
  logic             ch_ok, seq_ok, off_ok;
  chan_t            cmem_rdata, entry, entry_new;
  logic [LNW-1:0]   lmem_rdata, len_cur, len_new;
  logic [MAX_FRAGS-1:0] seq_bit;
  logic             bit_set, seen, incons, complete;
  logic [5:0]       misses;
  logic [6:0]       tot_sum;
  logic             store_do, cwe, lwe, pwe, pre;
  logic [PAW-1:0]   pwaddr, praddr;
  logic [7:0]       prdata;
  logic             out_free, exec_done, read_go, read_load;

  assign in_acc  = in_valid_i && in_ready_o;
  assign slot_in = LAW'(int'(channel_i) * MAX_FRAGS + int'(seq_i));

  // Item registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= fre_pkg::mode_e'(mode_i);
      ch_q   <= channel_i;
      seq_q  <= seq_i;
      left_q <= left_i;
      off_q  <= offset_i;
      fe_q   <= frag_end_i;
      data_q <= data_i;
      slot_q <= slot_in;
    end
    if (in_acc) begin
      byp_ent_q  <= entry_new;
      lbyp_len_q <= len_new;
    end
    len_q <= len_d;
    out_q <= out_d;
  end

  // Channel state and fragment length memories.
  fre_ram #(
    .WIDTH (EW),
    .DEPTH (CHANNELS)
  ) u_chan_ram (
    .clk_i   (clk_i),
    .we_i    (cwe),
    .waddr_i (cidx),
    .wdata_i (entry_new),
    .re_i    (in_acc),
    .raddr_i (CW'(channel_i)),
    .rdata_o (cmem_rdata)
  );

  fre_ram #(
    .WIDTH (LNW),
    .DEPTH (SLOTS)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (lwe),
    .waddr_i (slot_q),
    .wdata_i (len_new),
    .re_i    (in_acc),
    .raddr_i (slot_in),
    .rdata_o (lmem_rdata)
  );

  fre_ram #(
    .WIDTH (8),
    .DEPTH (BYTES)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (pwe),
    .waddr_i (pwaddr),
    .wdata_i (data_q),
    .re_i    (pre),
    .raddr_i (praddr),
    .rdata_o (prdata)
  );

  // Channel state of the registered word, with forwarding of a write made
  // in the cycle the word was accepted.
  always_comb begin
    cidx   = CW'(ch_q);
    sidx   = SW'(seq_q);
    ch_ok  = int'(ch_q) < CHANNELS;
    seq_ok = int'(seq_q) < MAX_FRAGS;
    off_ok = int'(off_q) < FRAG_BYTES;

    if (ch_ok && cvalid_q[cidx]) begin
      entry = byp_q ? byp_ent_q : cmem_rdata;
    end else begin
      entry = ChanReset;
    end
    len_cur = lbyp_q ? lbyp_len_q : lmem_rdata;

    seq_bit       = '0;
    seq_bit[sidx] = seq_ok;
    bit_set = seq_ok && ((entry.rx_map & seq_bit) != '0);

    seen     = entry.rx_map != '0;
    incons   = 7'(entry.rx_count) > 7'(entry.total);
    misses   = incons ? fre_pkg::MissesInconsistent
                      : 6'(7'(entry.total) - 7'(entry.rx_count));
    complete = seen && !incons && (misses == 6'd0);
    if (!seen) begin
      misses = 6'd0;
    end

    tot_sum   = 7'(left_q) + 7'(seq_q);
    entry_new = entry;
    entry_new.rx_map   = entry.rx_map | seq_bit;
    entry_new.rx_count = CNW'(entry.rx_count + CNW'(1));
    if (!seen || (sidx < entry.low_seq)) begin
      entry_new.low_seq = sidx;
      entry_new.total   = (tot_sum > 7'(fre_pkg::TotalMax)) ? fre_pkg::TotalMax
                                                           : tot_sum[5:0];
    end
    len_new = LNW'(int'(off_q) + 1);

    store_do = (state_q == fre_pkg::S_EXEC) && (mode_q == fre_pkg::MODE_STORE) &&
               ch_ok && seq_ok && off_ok && !bit_set;
    pwe    = store_do;
    cwe    = store_do && fe_q;
    lwe    = store_do && fe_q;
    pwaddr = PAW'(int'(slot_q) * FRAG_BYTES + int'(off_q));
    praddr = PAW'(int'(slot_q) * FRAG_BYTES + int'(rd_idx_q));
  end

  // Next state and outputs.
  always_comb begin
    state_d     = state_q;
    cvalid_d    = cvalid_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    len_d       = len_q;
    rd_idx_d    = rd_idx_q;
    pend_d      = pend_q;
    pend_last_d = pend_last_q;
    out_free    = !out_valid_q || out_ready_i;
    exec_done   = 1'b0;
    read_go     = 1'b0;
    read_load   = 1'b0;
    pre         = 1'b0;

    out_d.status   = fre_pkg::ST_ACK;
    out_d.byte_out = 8'd0;
    out_d.last     = 1'b1;
    out_d.seen     = 1'b0;
    out_d.misses   = 6'd0;
    out_d.complete = 1'b0;
    if (!(state_q == fre_pkg::S_EXEC || state_q == fre_pkg::S_READ)) begin
      out_d = out_q;
    end

    unique case (state_q)
      fre_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = fre_pkg::S_EXEC;
        end
      end

      fre_pkg::S_EXEC: begin
        unique case (mode_q)
          fre_pkg::MODE_STORE: begin
            exec_done = 1'b1;
            if (cwe) begin
              cvalid_d[cidx] = 1'b1;
            end
          end
          fre_pkg::MODE_QUERY: begin
            exec_done      = out_free;
            out_d.status   = fre_pkg::ST_STATUS;
            out_d.seen     = seen;
            out_d.misses   = misses;
            out_d.complete = complete;
          end
          fre_pkg::MODE_READ: begin
            if (complete && bit_set && (len_cur != '0)) begin
              read_go = 1'b1;
            end else begin
              exec_done      = out_free;
              out_d.status   = fre_pkg::ST_ABSENT;
              out_d.seen     = seen;
              out_d.misses   = misses;
              out_d.complete = complete;
            end
          end
          fre_pkg::MODE_CLEAR: begin
            exec_done = out_free;
            if (out_free && ch_ok) begin
              cvalid_d[cidx] = 1'b0;
            end
          end
          default: begin
            exec_done = 1'b1;
          end
        endcase

        if (read_go) begin
          state_d     = fre_pkg::S_READ;
          len_d       = len_cur;
          rd_idx_d    = '0;
          pend_d      = 1'b0;
          pend_last_d = 1'b0;
          out_d       = out_q;
        end else if (exec_done) begin
          if (mode_q != fre_pkg::MODE_STORE) begin
            out_valid_d = 1'b1;
          end else begin
            out_d = out_q;
          end
          state_d = in_acc ? fre_pkg::S_EXEC : fre_pkg::S_IDLE;
        end else begin
          out_d = out_q;
        end
      end

      fre_pkg::S_READ: begin
        // The payload memory holds its read data until the result register
        // can take it, so at most one byte is in flight.
        read_load = pend_q && out_free;
        pre       = (rd_idx_q < len_q) && (!pend_q || out_free);
        pend_d    = pre || (pend_q && !out_free);
        if (pre) begin
          pend_last_d = (LNW'(rd_idx_q + LNW'(1)) == len_q);
          rd_idx_d    = LNW'(rd_idx_q + LNW'(1));
        end
        if (read_load) begin
          out_valid_d    = 1'b1;
          out_d.status   = fre_pkg::ST_BYTE;
          out_d.byte_out = prdata;
          out_d.last     = pend_last_q;
          if (pend_last_q) begin
            state_d = fre_pkg::S_IDLE;
          end
        end else begin
          out_d = out_q;
        end
      end

      default: begin
        state_d = fre_pkg::S_IDLE;
      end
    endcase

    in_ready_o = (state_q == fre_pkg::S_IDLE) ||
                 ((state_q == fre_pkg::S_EXEC) && exec_done && !read_go);

    if (in_acc) begin
      byp_d  = cwe && (CW'(channel_i) == cidx);
      lbyp_d = lwe && (slot_in == slot_q);
    end else begin
      byp_d  = byp_q;
      lbyp_d = lbyp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fre_pkg::S_IDLE;
      cvalid_q    <= '0;
      out_valid_q <= 1'b0;
      byp_q       <= 1'b0;
      lbyp_q      <= 1'b0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      rd_idx_q    <= '0;
    end else begin
      state_q     <= state_d;
      cvalid_q    <= cvalid_d;
      out_valid_q <= out_valid_d;
      byp_q       <= byp_d;
      lbyp_q      <= lbyp_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
      rd_idx_q    <= rd_idx_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_q.status;
  assign byte_out_o  = out_q.byte_out;
  assign last_o      = out_q.last;
  assign seen_o      = out_q.seen;
  assign misses_o    = out_q.misses;
  assign complete_o  = out_q.complete;

endmodule

// ===== hw/rtl/fre_checker.sv =====
// Port-level checker of the fragment reassembly engine, bound to the top level.
// Depends on fre_pkg and fragment_reassembly_engine_unit_defines.svh.
`include "fragment_reassembly_engine_unit_defines.svh"

module fre_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] status_o,
  input logic [7:0] byte_out_o,
  input logic       last_o,
  input logic       seen_o,
  input logic [5:0] misses_o,
  input logic       complete_o
);

  logic status_word;
  logic ack_word;

  assign status_word = out_valid_o && (status_o != fre_pkg::ST_BYTE);
  assign ack_word    = out_valid_o && (status_o == fre_pkg::ST_ACK);

  // No result word is offered while reset is held.
  `FRE_ASSERT_RST(a_no_out_in_reset, !rst_ni |-> !out_valid_o, "result word during reset")

  // A stalled result word holds.
  `FRE_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(byte_out_o) && $stable(last_o) && $stable(misses_o), "stalled result word changed")

  // Every word other than a payload byte is the only result of its item.
  `FRE_ASSERT(a_single_last, status_word |-> last_o, "single result word without last")

  // A complete channel has been seen and misses nothing.
  `FRE_ASSERT(a_complete_ok, out_valid_o && complete_o |-> seen_o && (misses_o == 6'd0) && (in_ready_o || !in_valid_i || in_ready_o == 1'b0), "complete with misses or unseen")

  // An acknowledge carries no status and no byte.
  `FRE_ASSERT(a_ack_clean, ack_word |-> !seen_o && !complete_o && (misses_o == 6'd0) && (byte_out_o == 8'd0), "acknowledge with status fields set")

endmodule

bind fragment_reassembly_engine_unit fre_checker u_fre_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .byte_out_o  (byte_out_o),
  .last_o      (last_o),
  .seen_o      (seen_o),
  .misses_o    (misses_o),
  .complete_o  (complete_o)
);
